### hdl/image_convolution_filter_assert.svh
// Assertion macros for the port-level checker of the convolution filter
`ifndef IMAGE_CONVOLUTION_FILTER_ASSERT_SVH
`define IMAGE_CONVOLUTION_FILTER_ASSERT_SVH

// clocked check, idle while reset is high
`define ICF_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define ICF_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/icf_pkg.sv
// Shared types and constants of the convolution filter
package icf_pkg;

  localparam int DEF_MAX_KERNEL = 11;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int WEIGHT_BITS    = 16;
  localparam int FRAC_BITS      = 8;
  localparam int PIX_BITS       = 8;
  localparam int PIX_MAX        = 255;
  localparam int ROW_BITS       = 12;
  localparam int COL_BITS       = 10;
  localparam int KSZ_BITS       = 4;
  localparam int WID_BITS       = 11;
  localparam int HGT_BITS       = 13;
  localparam int COORD_BITS     = 14;
  localparam int ACC_BITS       = 32;
  localparam int PROD_BITS      = WEIGHT_BITS + PIX_BITS + 1;
  localparam int TDATA_BITS     = 32;
  localparam int CIDX_BITS      = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_DRAIN = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [CIDX_BITS-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CIDX_BITS-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CIDX_BITS-1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_PREP,
    ST_TAP,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic check;
    logic prep;
    logic tap_step;
    logic finish;
  } icf_cmd_t;

  typedef struct packed {
    func_t func;
    logic  ready_hit;
    logic  tap_last;
    logic  pipe_busy;
    logic  out_free;
  } icf_status_t;

endpackage

### hdl/image_convolution_filter.sv
// Top level of the streaming zero-padded 2-D convolution filter
// Each input transfer is handled alone. A coefficient load or an unused func code passes
// through the update state back to idle; a pixel or drain item that frees no result
// passes through the update and check states. A pixel or drain item that releases a result
// walks the whole n-by-n window at one tap per cycle through the single read port of the
// line store and the one multiplier, then flushes the MAC pipeline and waits in the finish
// state while an earlier result still stalls in the output register. Results wait in that
// output register, so the next item is taken while a result is still pending. No clearing
// pass after reset: coefficient entries read as zero until loaded. A configuration
// write restarts the frame and is taken only between items.
module image_convolution_filter import icf_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,   // tap_row, tap_col, tap_weight, gray_in
  input  logic [1:0]            s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,   // gray_out, out_row, out_col, zero pad
  output logic                  m_tlast,   // frame_done
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_BITS-1:0]  cfg_index,
  input  logic [HGT_BITS-1:0]   cfg_data
);

  icf_cmd_t    cmd;
  icf_status_t status;

  icf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  icf_datapath #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

### hdl/icf_ctrl.sv
// Sequencer of the convolution filter: item intake, window walk, result hand-off
module icf_ctrl import icf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  icf_status_t status,
  output icf_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && !cfg_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.func == FUNC_PIXEL || status.func == FUNC_DRAIN) state_next = ST_CHECK;
        else state_next = ST_IDLE;
      end
      ST_CHECK: begin
        state_next = status.ready_hit ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        state_next = ST_TAP;
      end
      ST_TAP: begin
        if (status.tap_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!status.pipe_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ST_IDLE) && !cfg_valid;
    cfg_ready    = (state == ST_IDLE);
    cmd.accept   = (state == ST_IDLE) && s_tvalid && !cfg_valid;
    cmd.update   = (state == ST_UPDATE);
    cmd.check    = (state == ST_CHECK);
    cmd.prep     = (state == ST_PREP);
    cmd.tap_step = (state == ST_TAP);
    cmd.finish   = (state == ST_FINISH) && status.out_free;
  end

endmodule

### hdl/icf_datapath.sv
// Datapath of the convolution filter: stores, counters, multiply-accumulate, output register
module icf_datapath import icf_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  icf_cmd_t              cmd,
  output icf_status_t           status,
  input  logic [TDATA_BITS-1:0] s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CIDX_BITS-1:0]  cfg_index,
  input  logic [HGT_BITS-1:0]   cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int RING   = MAX_KERNEL * MAX_WIDTH;
  localparam int RA     = $clog2(RING);
  localparam int WDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int KB     = $clog2(MAX_KERNEL + 1);
  localparam int WB     = $clog2(MAX_WIDTH + 1);
  localparam int CB     = $clog2(MAX_WIDTH);
  localparam int N_RST  = (3 > MAX_KERNEL) ? MAX_KERNEL : 3;
  localparam int W_RST  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam logic signed [ACC_BITS-1:0] SUM_MAX  = ACC_BITS'(PIX_MAX * (1 << FRAC_BITS));
  localparam logic signed [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1 << (FRAC_BITS - 1));

  // configuration, kept clipped to the legal range
  logic [KB-1:0]       n_q;
  logic [WB-1:0]       w_q;
  logic [HGT_BITS-1:0] h_q;
  logic [KB-1:0]       half, after;
  logic [KB-1:0]       n_new;
  logic [WB-1:0]       w_new;
  logic [HGT_BITS-1:0] h_new;
  logic                cfg_hit;

  // latched item
  func_t                   func_q;
  logic [KSZ_BITS-1:0]     trow_q, tcol_q;
  logic [WEIGHT_BITS-1:0]  twt_q;
  logic [PIX_BITS-1:0]     gray_q;

  // stream position
  logic [ROW_BITS-1:0] in_row, er;
  logic [CB-1:0]       in_col, ec;
  logic                full;
  logic [RA-1:0]       wptr, eptr;

  // stores
  logic [PIX_BITS-1:0]    lmem [RING];
  logic [WEIGHT_BITS-1:0] wmem [WDEPTH];
  logic [WDEPTH-1:0]      wvalid;

  // window walk
  logic [RA-1:0]   hw_q, row_addr, laddr;
  logic [KB-1:0]   k, m;
  logic [WA-1:0]   wrow, waddr;
  logic signed [COORD_BITS-1:0] x, y, x0;
  logic [RA-1:0]   laddr_inc, row_addr_inc, start_addr;
  logic [RA:0]     off;

  // MAC pipeline
  logic [PIX_BITS-1:0]           lrd;
  logic signed [WEIGHT_BITS-1:0] wrd;
  logic                          s1_valid, s1_mask, s2_valid;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc, rnd;
  logic                          in_bounds;

  // item bookkeeping
  logic [ROW_BITS:0]  in_row_inc, nr, nr_raw;
  logic [CB:0]        in_col_inc, nc, nc_raw, ec_inc;
  logic               tap_ok, last;
  logic [PIX_BITS-1:0] pix;
  logic [WA-1:0]      load_addr;

  assign half  = n_q >> 1;
  assign after = n_q - KB'(1) - half;

  always_comb begin
    if (cfg_data[KSZ_BITS-1:0] == '0) n_new = KB'(1);
    else if (int'(cfg_data[KSZ_BITS-1:0]) > MAX_KERNEL) n_new = KB'(MAX_KERNEL);
    else n_new = KB'(cfg_data[KSZ_BITS-1:0]);
    if (cfg_data[WID_BITS-1:0] == '0) w_new = WB'(1);
    else if (int'(cfg_data[WID_BITS-1:0]) > MAX_WIDTH) w_new = WB'(MAX_WIDTH);
    else w_new = WB'(cfg_data[WID_BITS-1:0]);
    if (cfg_data == '0) h_new = HGT_BITS'(1);
    else if (int'(cfg_data) > MAX_HEIGHT) h_new = HGT_BITS'(MAX_HEIGHT);
    else h_new = cfg_data;
  end

  assign cfg_hit = cfg_valid && cfg_ready &&
                   (cfg_index == CFG_KERNEL || cfg_index == CFG_WIDTH ||
                    cfg_index == CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_q <= KB'(N_RST);
      w_q <= WB'(W_RST);
      h_q <= HGT_BITS'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KERNEL: n_q <= n_new;
        CFG_WIDTH:  w_q <= w_new;
        CFG_HEIGHT: h_q <= h_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= func_t'(s_tuser);
      trow_q <= s_tdata[3:0];
      tcol_q <= s_tdata[7:4];
      twt_q  <= s_tdata[23:8];
      gray_q <= s_tdata[31:24];
    end
  end

  // ready test: the bottom-right pixel of the window has arrived
  assign in_row_inc = {1'b0, in_row} + (ROW_BITS+1)'(1);
  assign in_col_inc = {1'b0, in_col} + (CB+1)'(1);
  assign ec_inc     = {1'b0, ec} + (CB+1)'(1);
  assign nr_raw     = {1'b0, er} + (ROW_BITS+1)'(after);
  assign nc_raw     = {1'b0, ec} + (CB+1)'(after);
  assign nr = (nr_raw > (ROW_BITS+1)'(h_q - 1'b1)) ? (ROW_BITS+1)'(h_q - 1'b1) : nr_raw;
  assign nc = (nc_raw > (CB+1)'(w_q - 1'b1)) ? (CB+1)'(w_q - 1'b1) : nc_raw;
  assign last = (HGT_BITS'(er) == h_q - 1'b1) && (WB'(ec) == w_q - 1'b1);

  assign tap_ok    = (int'(trow_q) < MAX_KERNEL) && (int'(tcol_q) < MAX_KERNEL);
  assign load_addr = WA'(int'(trow_q) * MAX_KERNEL + int'(tcol_q));

  always_comb begin
    status.func      = func_q;
    status.ready_hit = full || (nr < (ROW_BITS+1)'(in_row)) ||
                       ((nr == (ROW_BITS+1)'(in_row)) && (nc < (CB+1)'(in_col)));
    status.tap_last  = (k == n_q - KB'(1)) && (m == n_q - KB'(1));
    status.pipe_busy = s1_valid || s2_valid;
    status.out_free  = !m_tvalid || m_tready;
  end

  // stream counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_row <= '0;
      in_col <= '0;
      er     <= '0;
      ec     <= '0;
      full   <= 1'b0;
      wptr   <= '0;
      eptr   <= '0;
    end else begin
      if (cmd.update && func_q == FUNC_PIXEL && !full) begin
        if (in_col_inc >= (CB+1)'(w_q)) begin
          in_col <= '0;
          if ((HGT_BITS)'(in_row_inc) >= h_q) begin
            in_row <= '0;
            full   <= 1'b1;
            wptr   <= '0;
          end else begin
            in_row <= ROW_BITS'(in_row_inc);
            wptr   <= (int'(wptr) == RING - 1) ? '0 : wptr + RA'(1);
          end
        end else begin
          in_col <= CB'(in_col_inc);
          wptr   <= (int'(wptr) == RING - 1) ? '0 : wptr + RA'(1);
        end
      end
      if (cmd.finish) begin
        if (last) begin
          er   <= '0;
          ec   <= '0;
          full <= 1'b0;
          eptr <= '0;
        end else begin
          if (ec_inc >= (CB+1)'(w_q)) begin
            ec <= '0;
            er <= er + ROW_BITS'(1);
          end else begin
            ec <= CB'(ec_inc);
          end
          eptr <= (int'(eptr) == RING - 1) ? '0 : eptr + RA'(1);
        end
      end
    end
  end

  // line store: one write port for arriving pixels, one registered read for the walk
  always_ff @(posedge clk) begin
    if (cmd.update && func_q == FUNC_PIXEL && !full) lmem[wptr] <= gray_q;
    lrd <= lmem[laddr];
  end

  // coefficient store, entries read as zero until loaded
  always_ff @(posedge clk) begin
    if (cmd.update && func_q == FUNC_LOAD && tap_ok) wmem[load_addr] <= twt_q;
    wrd <= wvalid[waddr] ? $signed(wmem[waddr]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (cmd.update && func_q == FUNC_LOAD && tap_ok) begin
      wvalid[load_addr] <= 1'b1;
    end
  end

  // ring addresses: the step addresses each a single add with wrap, the window start a wrapped subtract
  always_comb begin
    logic [RA:0] s1, s2;
    s1 = (RA+1)'(laddr) + (RA+1)'(1);
    s2 = (RA+1)'(row_addr) + (RA+1)'(w_q);
    laddr_inc    = (s1 >= (RA+1)'(RING)) ? RA'(s1 - (RA+1)'(RING)) : RA'(s1);
    row_addr_inc = (s2 >= (RA+1)'(RING)) ? RA'(s2 - (RA+1)'(RING)) : RA'(s2);
    off = (RA+1)'(hw_q) + (RA+1)'(half);
    if ((RA+1)'(eptr) >= off) start_addr = RA'((RA+1)'(eptr) - off);
    else start_addr = RA'((RA+1)'(eptr) + (RA+1)'(RING) - off);
  end

  assign x0 = COORD_BITS'(ec) - COORD_BITS'(half);
  assign in_bounds = (y >= 0) && (y < $signed(COORD_BITS'(h_q))) &&
                     (x >= 0) && (x < $signed(COORD_BITS'(w_q)));

  // window walk, one tap per cycle
  always_ff @(posedge clk) begin
    if (cmd.check) hw_q <= RA'(half * w_q);
    if (cmd.prep) begin
      row_addr <= start_addr;
      laddr    <= start_addr;
      y        <= COORD_BITS'(er) - COORD_BITS'(half);
      x        <= x0;
      k        <= '0;
      m        <= '0;
      wrow     <= '0;
      waddr    <= '0;
    end else if (cmd.tap_step) begin
      if (m == n_q - KB'(1)) begin
        m        <= '0;
        k        <= k + KB'(1);
        y        <= y + COORD_BITS'(1);
        x        <= x0;
        row_addr <= row_addr_inc;
        laddr    <= row_addr_inc;
        wrow     <= WA'(int'(wrow) + MAX_KERNEL);
        waddr    <= WA'(int'(wrow) + MAX_KERNEL);
      end else begin
        m     <= m + KB'(1);
        x     <= x + COORD_BITS'(1);
        laddr <= laddr_inc;
        waddr <= waddr + WA'(1);
      end
    end
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.tap_step;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_mask <= in_bounds;
    prod    <= s1_mask ? PROD_BITS'(wrd * $signed({1'b0, lrd})) : '0;
    if (cmd.prep) acc <= '0;
    else if (s2_valid) acc <= acc + ACC_BITS'(prod);
  end

  // clamp and round half up
  assign rnd = acc + HALF_LSB;
  always_comb begin
    if (acc < 0) pix = '0;
    else if (acc > SUM_MAX) pix = PIX_BITS'(PIX_MAX);
    else pix = rnd[FRAC_BITS +: PIX_BITS];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {2'b00, COL_BITS'(ec), er, pix};
      m_tlast <= last;
    end
  end

endmodule

### hdl/icf_checker.sv
// Port-level checks of the convolution filter, bound to the top level
`include "image_convolution_filter_assert.svh"

module icf_checker import icf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [TDATA_BITS-1:0] s_tdata,
  input logic [1:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_BITS-1:0] m_tdata,
  input logic                  m_tlast,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CIDX_BITS-1:0]  cfg_index,
  input logic [HGT_BITS-1:0]   cfg_data
);

  // a stalled result holds
  `ICF_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
  // one item in work at a time
  `ICF_CHECK(a_one_item, s_tvalid && s_tready |=> !s_tready, "item taken while another is in work")
  // a register write and an item transfer never share a cycle
  `ICF_CHECK(a_cfg_excl, cfg_valid && cfg_ready |-> !(s_tvalid && s_tready), "config write during item transfer")
  // nothing to show right after reset
  `ICF_CHECK_RST(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind image_convolution_filter icf_checker u_icf_checker (.*);

### verif/image_convolution_filter_checker.sv
// Checker for the convolution filter: predicts filtered pixels and compares transfers
module image_convolution_filter_checker import icf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [TDATA_BITS-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CIDX_BITS-1:0]  cfg_index,
  input  logic [HGT_BITS-1:0]   cfg_data,
  output int                    pending,
  output int                    errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KMAX = DEF_MAX_KERNEL;
  localparam int RING = DEF_MAX_KERNEL * DEF_MAX_WIDTH;

  typedef struct {
    logic [PIX_BITS-1:0] gray;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                done;
  } filtered_pixel_t;

  filtered_pixel_t     expected_pixels[$];
  logic signed [15:0]  coef[KMAX*KMAX];
  logic [7:0]          ring_pix[RING];
  int                  in_row, in_col, out_row, out_col;
  bit                  frame_full;
  int                  kernel_reg, width_reg, height_reg;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    frame_full = 0;
  endtask

  task automatic restart_frame_out();
    out_row = 0; out_col = 0;
    frame_full = 0;
  endtask

  task automatic filter_item(func_t f, logic [TDATA_BITS-1:0] d);
    int n, w, h, half, after, nr, nc, y, x;
    bit ready;
    longint sum;
    filtered_pixel_t res;
    if (f == FUNC_LOAD) begin
      if (d[3:0] < KMAX && d[7:4] < KMAX) coef[d[3:0]*KMAX + d[7:4]] = d[23:8];
      return;
    end
    if (f == FUNC_NONE) return;
    n = clip(kernel_reg, 1, KMAX);
    w = clip(width_reg, 1, DEF_MAX_WIDTH);
    h = clip(height_reg, 1, MAX_HEIGHT);
    half = n / 2;
    after = n - 1 - half;
    if (f == FUNC_PIXEL && !frame_full) begin
      ring_pix[(in_row*w + in_col) % RING] = d[31:24];
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          frame_full = 1;
        end
      end
    end
    if (frame_full) ready = 1;
    else begin
      nr = (out_row + after > h - 1) ? h - 1 : out_row + after;
      nc = (out_col + after > w - 1) ? w - 1 : out_col + after;
      ready = nr < in_row || (nr == in_row && nc < in_col);
    end
    if (!ready) return;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      y = out_row + k - half;
      if (y < 0 || y >= h) continue;
      for (int m = 0; m < n; m++) begin
        x = out_col + m - half;
        if (x < 0 || x >= w) continue;
        sum += longint'(coef[k*KMAX + m]) * longint'(ring_pix[(y*w + x) % RING]);
      end
    end
    if (sum < 0) res.gray = '0;
    else if (sum > longint'(PIX_MAX) * 256) res.gray = PIX_BITS'(PIX_MAX);
    else res.gray = PIX_BITS'((sum + 128) >>> FRAC_BITS);
    res.row = ROW_BITS'(out_row);
    res.col = COL_BITS'(out_col);
    res.done = (out_row == h - 1) && (out_col == w - 1);
    expected_pixels.push_back(res);
    if (res.done) restart_frame_out();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic compare_result();
    filtered_pixel_t e;
    if (expected_pixels.size() == 0) begin
      report($sformatf("unexpected result data %h last %b", m_tdata, m_tlast));
      return;
    end
    e = expected_pixels.pop_front();
    if (m_tdata[7:0] !== e.gray)
      report($sformatf("gray_out %0d, want %0d at (%0d,%0d)", m_tdata[7:0], e.gray, e.row, e.col));
    if (m_tdata[19:8] !== e.row)
      report($sformatf("out_row %0d, want %0d", m_tdata[19:8], e.row));
    if (m_tdata[29:20] !== e.col)
      report($sformatf("out_col %0d, want %0d", m_tdata[29:20], e.col));
    if (m_tdata[31:30] !== 2'b00)
      report($sformatf("pad bits %b not zero", m_tdata[31:30]));
    if (m_tlast !== e.done)
      report($sformatf("frame_done %b, want %b at (%0d,%0d)", m_tlast, e.done, e.row, e.col));
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      foreach (coef[i]) coef[i] = '0;
      kernel_reg = 3; width_reg = 640; height_reg = 480;
      restart_frame();
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KERNEL: kernel_reg = cfg_data[3:0];
          CFG_WIDTH:  width_reg  = cfg_data[10:0];
          CFG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
        if (cfg_index inside {CFG_KERNEL, CFG_WIDTH, CFG_HEIGHT}) restart_frame();
      end
      if (s_tvalid && s_tready) filter_item(func_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) compare_result();
    end
    pending <= expected_pixels.size();
  end
endmodule

### verif/image_convolution_filter_test.sv
// Stimulus and verdict for the convolution filter testbench
module image_convolution_filter_test;
  import icf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata = '0;
  logic [1:0]            s_tuser = FUNC_NONE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CIDX_BITS-1:0]  cfg_index = CFG_KERNEL;
  logic [HGT_BITS-1:0]   cfg_data = '0;
  int                    pending, errors;
  int                    items_sent = 0;

  image_convolution_filter dut (.*);
  image_convolution_filter_checker chk (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #4000000;
    $display("image_convolution_filter_test NOT OK");
    $finish;
  end

  // random input gaps and output stalls, none while items 300 to 599 are sent
  function automatic bit idle_now();
    return ($urandom_range(99) < 17) && !(items_sent >= 300 && items_sent < 600);
  endfunction

  always @(negedge clk) m_tready <= !idle_now();

  task automatic send_item(func_t f, logic [3:0] r, logic [3:0] c,
                           logic [15:0] wt, logic [7:0] pix);
    @(negedge clk);
    while (idle_now()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {pix, wt, c, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [CIDX_BITS-1:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= HGT_BITS'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block may still be busy on a no-result item after the last result
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_weight(int mode);
    case (mode)
      0: return 16'($urandom_range(400) - 150);
      1: return 16'($urandom);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return $urandom_range(1) ? 16'd128 : 16'd0;
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_frame(int n, int w, int h, int max_pix);
    int kn, kw, kh, mode, npix, ndrain;
    kn = (n < 1) ? 1 : (n > 11) ? 11 : n;
    kw = (w < 1) ? 1 : (w > 1024) ? 1024 : w;
    kh = (h < 1) ? 1 : (h > 4096) ? 4096 : h;
    mode = $urandom_range(3);
    wait_quiet();
    write_reg(CFG_KERNEL, n);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    for (int k = 0; k < kn; k++)
      for (int m = 0; m < kn; m++)
        send_item(FUNC_LOAD, 4'(k), 4'(m), pick_weight(mode), 8'($urandom));
    send_item(FUNC_NONE, 4'($urandom), 4'($urandom), 16'($urandom), 8'($urandom));
    send_item(FUNC_LOAD, 4'($urandom_range(15, 11)), 4'($urandom), 16'($urandom), 8'($urandom));
    send_item(FUNC_DRAIN, 4'($urandom), 4'($urandom), 16'($urandom), 8'($urandom));
    npix = (kw * kh < max_pix) ? kw * kh : max_pix;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < 5)
        send_item(FUNC_DRAIN, 4'($urandom), 4'($urandom), 16'($urandom), 8'($urandom));
      send_item(FUNC_PIXEL, 4'($urandom), 4'($urandom), 16'($urandom), pick_pixel());
    end
    ndrain = (kn - 1 - kn / 2 + 1) * kw + 2;
    if (ndrain > 40) ndrain = 40;
    for (int i = 0; i < ndrain; i++)
      send_item($urandom_range(3) == 0 ? FUNC_PIXEL : FUNC_DRAIN, 4'($urandom), 4'($urandom),
                16'($urandom), pick_pixel());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // reset values in use: 3x3 kernel on a 640-wide frame
    send_item(FUNC_LOAD, 4'd0, 4'd0, 16'h7fff, 8'd0);
    send_item(FUNC_LOAD, 4'd10, 4'd10, 16'h8000, 8'd0);
    send_item(FUNC_LOAD, 4'd15, 4'd15, 16'h1234, 8'd0);
    send_item(FUNC_LOAD, 4'd1, 4'd1, 16'd128, 8'd0);
    send_item(FUNC_NONE, 4'd0, 4'd0, 16'd0, 8'd0);
    send_item(FUNC_DRAIN, 4'd0, 4'd0, 16'd0, 8'd0);
    send_item(FUNC_PIXEL, 4'd0, 4'd0, 16'd0, 8'd0);
    send_item(FUNC_PIXEL, 4'd0, 4'd0, 16'd0, 8'd255);
    for (int i = 0; i < 8; i++)
      send_item(FUNC_PIXEL, 4'd0, 4'd0, 16'd0, pick_pixel());
    run_frame(1, 1, 1, 10);
    run_frame(11, 3, 3, 100);
    run_frame(0, 0, 0, 10);
    run_frame(15, 5, 4, 100);
    run_frame(2, 4, 3, 100);
    run_frame(11, 11, 11, 200);
    run_frame(3, 1024, 1, 150);
    run_frame(1, 1, 4096, 40);
    run_frame(13, 2047, 8191, 30);
    while (items_sent < 1100)
      run_frame($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(11, 1),
                $urandom_range(12, 1), $urandom_range(8, 1), 200);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("image_convolution_filter_test OK");
    else
      $display("image_convolution_filter_test NOT OK");
    $finish;
  end
endmodule
